FILE: hw/rtl/pksa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pksa_pkg
// Shared types and constants of the per-key sequence allocator.
// ----------------------------------------------------------------------------
package pksa_pkg;

  localparam int NUM_SLOTS  = 64;
  localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SLOT_CNT_W = $clog2(NUM_SLOTS + 1);

  localparam int KEY_W  = 32;
  localparam int ID_W   = 32;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [ID_W-1:0] ID_LIMIT = 32'hFFFF_0000;

  localparam logic [CFG_W-1:0] BATCH_RST = 16'd4096;
  localparam logic [CFG_W-1:0] FIRST_RST = 16'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BATCH_SIZE = 1'b0,
    CFG_FIRST_ID   = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_LIMIT   = 2'd2,
    ST_BAD_KEY = 2'd3
  } status_t;

  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

  // Command from the sequencer to the slot table.
  typedef struct packed {
    logic            rd_en;
    slot_idx_t       rd_addr;
    logic            key_we;
    logic            ctr_we;
    slot_idx_t       wr_addr;
    logic [KEY_W-1:0] key_wd;
    logic [ID_W-1:0] next_wd;
    logic [ID_W-1:0] mark_wd;
  } slot_cmd_t;

  // Registered read data of one slot.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  next_id;
    logic [ID_W-1:0]  mark;
  } slot_rd_t;

endpackage

FILE: hw/rtl/pksa_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pksa_in_if
// Request channel: key and its persisted mark.
// ----------------------------------------------------------------------------
interface pksa_in_if
  import pksa_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] shard_key;
  logic [ID_W-1:0]  stored_mark;

  modport source (output valid, output shard_key, output stored_mark, input ready);
  modport sink   (input valid, input shard_key, input stored_mark, output ready);
endinterface

FILE: hw/rtl/pksa_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pksa_out_if
// Result channel: issued id, status and persist request.
// ----------------------------------------------------------------------------
interface pksa_out_if
  import pksa_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] issued_id;
  status_t         status;
  logic            persist_request;
  logic [ID_W-1:0] persist_mark;

  modport source (output valid, output issued_id, output status,
                  output persist_request, output persist_mark, input ready);
  modport sink   (input valid, input issued_id, input status,
                  input persist_request, input persist_mark, output ready);
endinterface

FILE: hw/rtl/pksa_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pksa_slot_table
// Key, next id and mark storage with one shared read port, registered data.
// ----------------------------------------------------------------------------
module pksa_slot_table
  import pksa_pkg::*;
(
  input  logic      clk,
  input  slot_cmd_t cmd,
  output slot_rd_t  rd
);

  logic [KEY_W-1:0] key_mem  [NUM_SLOTS];
  logic [ID_W-1:0]  next_mem [NUM_SLOTS];
  logic [ID_W-1:0]  mark_mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (cmd.key_we) begin
      key_mem[cmd.wr_addr] <= cmd.key_wd;
    end
    if (cmd.ctr_we) begin
      next_mem[cmd.wr_addr] <= cmd.next_wd;
      mark_mem[cmd.wr_addr] <= cmd.mark_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd.key     <= key_mem[cmd.rd_addr];
      rd.next_id <= next_mem[cmd.rd_addr];
      rd.mark    <= mark_mem[cmd.rd_addr];
    end
  end

endmodule

FILE: hw/rtl/per_key_sequence_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_key_sequence_allocator_core
// Hands out per-key sequence ids from a slot table, extending the reserved
// mark one batch at a time and requesting its persistence.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents                               | handshake
//  --------+-----+---------------------------------------------+-------------
//  in_ch   | in  | shard_key, stored_mark                      | valid/ready
//  out_ch  | out | issued_id, status, persist_request/mark     | valid/ready
//  cfg_*   | in  | cfg_idx selects register, cfg_wdata value   | cfg_we only
//
//  One request at a time. A request passes accept, scan, load (on a hit),
//  update and output steps; its length is set by the key compare that walks
//  the occupied slots through the table's single read port. Key zero skips the
//  scan. Slots fill in order and are never freed, so a fill count marks the
//  occupied prefix; reset clears it with no clearing pass. in_ch.ready is low
//  while a request or its result beat is in flight; a stalled result beat
//  holds until out_ch.ready.
//
module per_key_sequence_allocator_core
  import pksa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  pksa_in_if.sink              in_ch,
  pksa_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LOAD,
    S_EXEC,
    S_OUT
  } state_t;

  state_t                state_r;
  logic [KEY_W-1:0]      key_r;
  logic [ID_W-1:0]       stored_r;
  logic [SLOT_CNT_W-1:0] scan_r;
  logic [SLOT_CNT_W-1:0] fill_r;
  logic                  cmp_vld_r;
  slot_idx_t             cmp_idx_r;
  slot_idx_t             slot_r;
  logic [ID_W-1:0]       cur_next_r;
  logic [ID_W-1:0]       cur_mark_r;
  logic [CFG_W-1:0]      batch_r;
  logic [CFG_W-1:0]      first_r;

  logic [ID_W-1:0]       id_r;
  status_t               status_r;
  logic                  preq_r;
  logic [ID_W-1:0]       pmark_r;

  slot_cmd_t             cmd;
  slot_rd_t              rd;

  logic                  hit;
  logic                  scan_more;
  logic                  absent;
  logic                  full;
  logic [ID_W-1:0]       first_ext;
  logic [ID_W-1:0]       start_id;
  logic [ID_W-1:0]       batch_ext;
  logic [ID_W-1:0]       new_mark;
  logic                  at_limit;
  logic                  extend;

  pksa_slot_table u_table (
    .clk (clk),
    .cmd (cmd),
    .rd  (rd)
  );

  // Key compare against the slot read in the previous cycle.
  assign hit       = cmp_vld_r && (rd.key == key_r);
  assign scan_more = (scan_r != fill_r);
  assign absent    = !cmp_vld_r && !scan_more;
  assign full      = (fill_r == SLOT_CNT_W'(NUM_SLOTS));

  assign first_ext = {{(ID_W-CFG_W){1'b0}}, first_r};
  assign start_id  = (stored_r > first_ext) ? stored_r : first_ext;
  // Treat a zero batch as one.
  assign batch_ext = (batch_r == '0) ? ID_W'(1) : {{(ID_W-CFG_W){1'b0}}, batch_r};
  assign new_mark  = cur_next_r + batch_ext;
  assign at_limit  = (cur_next_r >= ID_LIMIT);
  assign extend    = (cur_next_r >= cur_mark_r);

  always_comb begin
    cmd         = '0;
    cmd.rd_en   = (state_r == S_SCAN);
    cmd.rd_addr = hit ? cmp_idx_r : scan_r[SLOT_IDX_W-1:0];
    cmd.key_wd  = key_r;
    cmd.wr_addr = slot_r;
    cmd.next_wd = at_limit ? cur_next_r : cur_next_r + ID_W'(1);
    cmd.mark_wd = (!at_limit && extend) ? new_mark : cur_mark_r;
    if (state_r == S_SCAN && !hit && absent && !full) begin
      // Claim the first empty slot, at the end of the occupied prefix.
      cmd.key_we  = 1'b1;
      cmd.wr_addr = fill_r[SLOT_IDX_W-1:0];
    end
    if (state_r == S_EXEC) begin
      cmd.ctr_we = 1'b1;
    end
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = (state_r == S_OUT);
  assign out_ch.issued_id       = id_r;
  assign out_ch.status          = status_r;
  assign out_ch.persist_request = preq_r;
  assign out_ch.persist_mark    = pmark_r;

  // Configuration registers; unknown indexes cannot occur with this width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_r <= BATCH_RST;
      first_r <= FIRST_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_BATCH_SIZE: batch_r <= cfg_wdata;
        CFG_FIRST_ID:   first_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      scan_r    <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            key_r     <= in_ch.shard_key;
            stored_r  <= in_ch.stored_mark;
            scan_r    <= '0;
            cmp_vld_r <= 1'b0;
            if (in_ch.shard_key == '0) begin
              // Drop key zero without touching the table.
              id_r     <= '0;
              status_r <= ST_BAD_KEY;
              preq_r   <= 1'b0;
              pmark_r  <= '0;
              state_r  <= S_OUT;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (hit) begin
            // Read of the hit slot's counters is issued this cycle.
            slot_r    <= cmp_idx_r;
            cmp_vld_r <= 1'b0;
            state_r   <= S_LOAD;
          end else if (absent) begin
            if (full) begin
              id_r     <= '0;
              status_r <= ST_FULL;
              preq_r   <= 1'b0;
              pmark_r  <= '0;
              state_r  <= S_OUT;
            end else begin
              slot_r     <= fill_r[SLOT_IDX_W-1:0];
              fill_r     <= fill_r + SLOT_CNT_W'(1);
              cur_next_r <= start_id;
              cur_mark_r <= start_id;
              state_r    <= S_EXEC;
            end
          end else begin
            // Advance the walk while occupied slots remain.
            cmp_vld_r <= scan_more;
            cmp_idx_r <= scan_r[SLOT_IDX_W-1:0];
            if (scan_more) begin
              scan_r <= scan_r + SLOT_CNT_W'(1);
            end
          end
        end

        S_LOAD: begin
          cur_next_r <= rd.next_id;
          cur_mark_r <= rd.mark;
          state_r    <= S_EXEC;
        end

        S_EXEC: begin
          if (at_limit) begin
            id_r     <= '0;
            status_r <= ST_LIMIT;
            preq_r   <= 1'b0;
            pmark_r  <= '0;
          end else begin
            id_r     <= cur_next_r;
            status_r <= ST_OK;
            preq_r   <= extend;
            pmark_r  <= extend ? new_mark : '0;
          end
          state_r <= S_OUT;
        end

        S_OUT: begin
          // Hold the result beat until taken.
          if (out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for per_key_sequence_allocator_core. It drives key
// requests through the valid/ready request channel under several idle and
// stall profiles and register settings. A slot-table tracker predicts each
// issued id, status and persist request, and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_top;
  import pksa_pkg::*;

  // One result beat as the block should produce it.
  typedef struct packed {
    logic [ID_W-1:0] issued_id;
    status_t         status;
    logic            persist_request;
    logic [ID_W-1:0] persist_mark;
  } grant_t;

  // Mirror of the slot table plus the queue of grants still owed by the block.
  class seq_id_tracker;
    logic [KEY_W-1:0] key_tab [NUM_SLOTS];
    logic [ID_W-1:0]  next_tab [NUM_SLOTS];
    logic [ID_W-1:0]  mark_tab [NUM_SLOTS];
    logic [CFG_W-1:0] batch;
    logic [CFG_W-1:0] first_id;
    grant_t           owed_grants [$];
    int               errors;

    function new();
      foreach (key_tab[i]) begin
        key_tab[i]  = '0;
        next_tab[i] = '0;
        mark_tab[i] = '0;
      end
      batch    = BATCH_RST;
      first_id = FIRST_RST;
      errors   = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_BATCH_SIZE: batch = val;
        CFG_FIRST_ID:   first_id = val;
        default: ;
      endcase
    endfunction

    function int owed();
      return owed_grants.size();
    endfunction

    // Predict the grant for an accepted request and update the table.
    function void note_request(logic [KEY_W-1:0] key, logic [ID_W-1:0] stored);
      grant_t          g;
      int              slot;
      int              vacant;
      logic [ID_W-1:0] start;
      logic [ID_W-1:0] stride;
      g.issued_id       = '0;
      g.status          = ST_OK;
      g.persist_request = 1'b0;
      g.persist_mark    = '0;
      slot   = -1;
      vacant = -1;
      if (key == '0) begin
        g.status = ST_BAD_KEY;
      end else begin
        for (int i = 0; i < NUM_SLOTS && slot < 0; i++) begin
          if (key_tab[i] == key) slot = i;
          else if (vacant < 0 && key_tab[i] == '0) vacant = i;
        end
        if (slot < 0 && vacant >= 0) begin
          slot  = vacant;
          start = (stored > {16'b0, first_id}) ? stored : {16'b0, first_id};
          key_tab[slot]  = key;
          next_tab[slot] = start;
          mark_tab[slot] = start;
        end
        if (slot < 0) begin
          g.status = ST_FULL;
        end else if (next_tab[slot] >= ID_LIMIT) begin
          g.status = ST_LIMIT;
        end else begin
          if (next_tab[slot] >= mark_tab[slot]) begin
            stride = (batch == '0) ? 32'd1 : {16'b0, batch};
            mark_tab[slot]    = next_tab[slot] + stride;
            g.persist_request = 1'b1;
            g.persist_mark    = mark_tab[slot];
          end
          g.issued_id    = next_tab[slot];
          next_tab[slot] = next_tab[slot] + 32'd1;
        end
      end
      owed_grants.push_back(g);
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_grant(grant_t got);
      grant_t want;
      if (owed_grants.size() == 0) begin
        $display("%0t: unexpected result beat: id %h status %0d persist %0b mark %h",
                 $time, got.issued_id, got.status, got.persist_request, got.persist_mark);
        errors++;
        return;
      end
      want = owed_grants.pop_front();
      match_field("issued_id", want.issued_id, got.issued_id);
      match_field("status", 32'(want.status), 32'(got.status));
      match_field("persist_request", 32'(want.persist_request), 32'(got.persist_request));
      match_field("persist_mark", want.persist_mark, got.persist_mark);
    endfunction

    function void flag_leftover();
      if (owed_grants.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $time, owed_grants.size());
        errors++;
      end
    endfunction
  endclass

  localparam int QUIET_LIMIT = 4000;  // cycles with no beat on either channel
  localparam int HOLD_CYCLES = 500;   // long receiver hold-off
  localparam int TAIL_CYCLES = 100;   // a bit over the worst request latency
  localparam int POOL_SIZE   = 80;    // more keys than slots, so the table fills
  localparam int PHASE_ITEMS = 250;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  pksa_in_if  in_ch ();
  pksa_out_if out_ch ();

  per_key_sequence_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  seq_id_tracker ledger;

  int   send_idle_pct;
  int   recv_stall_pct;
  logic hold_flip;
  logic hold_seen;
  int   hold_left;
  int   quiet_cycles;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: stall at random, or hold ready low for a long stretch when asked.
  always @(posedge clk) begin
    if (hold_flip !== hold_seen) begin
      hold_seen = hold_flip;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: sample both channels at the edge, before any new drive lands.
  always @(posedge clk) begin
    grant_t beat;
    if (rst_n === 1'b1) begin
      if (out_ch.valid && out_ch.ready) begin
        beat.issued_id       = out_ch.issued_id;
        beat.status          = out_ch.status;
        beat.persist_request = out_ch.persist_request;
        beat.persist_mark    = out_ch.persist_mark;
        ledger.check_grant(beat);
      end
      if (in_ch.valid && in_ch.ready)
        ledger.note_request(in_ch.shard_key, in_ch.stored_mark);
    end
  end

  // Watchdog: give up when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one request after a random idle gap and hold it until accepted.
  task automatic send_request(input logic [KEY_W-1:0] key, input logic [ID_W-1:0] mark);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.shard_key   <= key;
    in_ch.stored_mark <= mark;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Drop valid and wait until every owed grant has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (ledger.owed() != 0) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges; the block is idle here.
  task automatic set_config(input logic [CFG_W-1:0] batch, input logic [CFG_W-1:0] first);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_BATCH_SIZE;
    cfg_wdata <= batch;
    @(posedge clk);
    ledger.write_reg(CFG_BATCH_SIZE, batch);
    cfg_idx   <= CFG_FIRST_ID;
    cfg_wdata <= first;
    @(posedge clk);
    ledger.write_reg(CFG_FIRST_ID, first);
    cfg_we <= 1'b0;
  endtask

  // Mostly known keys, opened one at a time so claims spread over the run.
  function automatic logic [KEY_W-1:0] pick_key(int item_no);
    int r;
    int open;
    r    = $urandom_range(99);
    open = (8 + item_no / 25 < POOL_SIZE) ? 8 + item_no / 25 : POOL_SIZE;
    if (r < 3) return '0;
    if (r < 4) return $urandom;
    return key_pool[$urandom_range(open - 1)];
  endfunction

  // Stored marks around the first usable id, anywhere, and near the id limit.
  function automatic logic [ID_W-1:0] pick_mark();
    int r;
    r = $urandom_range(99);
    if (r < 25) return '0;
    if (r < 50) return $urandom_range(65535);
    if (r < 88) return $urandom;
    if (r < 96) return ID_LIMIT - $urandom_range(40);
    return ID_LIMIT | $urandom_range(16'hFFFF);
  endfunction

  initial begin
    logic [CFG_W-1:0] phase_batch [8];
    logic [CFG_W-1:0] phase_first [8];
    int item_no;
    ledger = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_flip      = 1'b0;
    hold_seen      = 1'b0;
    hold_left      = 0;
    quiet_cycles   = 0;
    item_no        = 0;
    foreach (key_pool[i]) begin
      key_pool[i] = $urandom;
      while (key_pool[i] == '0) key_pool[i] = $urandom;
    end
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.shard_key   <= '0;
    in_ch.stored_mark <= '0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_BATCH_SIZE;
    cfg_wdata         <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings first.
    send_request(32'h0000_0000, 32'h0000_0000);  // key zero is refused
    send_request(32'h0000_0000, 32'hFFFF_FFFF);
    send_request(32'h0000_0001, 32'h0000_0000);  // claim at first id, extend
    send_request(32'h0000_0001, 32'h0000_0000);  // plain issue
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);  // claimed past the limit
    send_request(32'hFFFF_FFFF, 32'h0000_0000);  // stays at the limit
    send_request(32'h8000_0000, 32'hFFFE_FFFF);  // last id below the limit
    send_request(32'h8000_0000, 32'h0000_0000);  // now at the limit
    send_request(32'h1234_5678, ID_LIMIT);       // exactly at the limit
    send_request(32'h0000_0002, 32'h0000_0002);  // mark below first id
    send_request(32'h0000_0003, 32'h0000_0003);  // mark equal to first id
    send_request(32'h0000_0004, 32'h0000_0004);  // mark above first id

    // Smallest batch, largest first id: a new key extends its mark on every id.
    drain();
    set_config(16'd1, 16'hFFFF);
    send_request(32'h0000_0005, 32'h0000_0000);
    send_request(32'h0000_0005, 32'h0000_0000);
    send_request(32'h0000_0001, 32'h0000_0000);

    // Zero batch acts as one; zero first id.
    drain();
    set_config(16'd0, 16'd0);
    send_request(32'h0000_0006, 32'h0000_0000);
    send_request(32'h0000_0006, 32'h0000_0000);

    // Largest batch.
    drain();
    set_config(16'hFFFF, 16'd0);
    send_request(32'h0000_0007, 32'h0000_000A);
    send_request(32'h0000_0007, 32'h0000_000A);

    // Random phases, each with its own settings and one of four idle and stall profiles.
    phase_batch = '{16'd4096, 16'd1, 16'hFFFF, 16'd0, 16'd3,
                    16'($urandom_range(1, 16)), 16'hFFFF, 16'd2};
    phase_first = '{16'd3, 16'd0, 16'hFFFF, 16'd1000, 16'($urandom),
                    16'($urandom), 16'd0, 16'hFFFF};
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      set_config(phase_batch[ph], phase_first[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      // Hold the receiver off while requests keep coming, so the block backs up.
      if (ph == 4) hold_flip <= ~hold_flip;
      repeat (PHASE_ITEMS) begin
        send_request(pick_key(item_no), pick_mark());
        item_no++;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    ledger.flag_leftover();
    if (ledger.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
